/* src/pon_pkg.sv */
package pon_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TABLE_SIZE  = 256;
  localparam int MAX_OCTAVES = 8;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int OCT_W       = $clog2(MAX_OCTAVES);
  localparam int OCT_CNT_W   = 4;
  localparam int PERS_W      = 17;
  localparam int FADE_W      = FRAC_BITS + 1;
  localparam int GRAD_W      = FRAC_BITS + 2;
  localparam int LERP_W      = FRAC_BITS + 4;
  localparam int MUL_W       = 24;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 40;
  localparam int WSUM_W      = 20;
  localparam int OUT_W       = 18;
  localparam int STEP_W      = $clog2(ACC_W);
  localparam int ONE_FX      = 1 << FRAC_BITS;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] LVL_X = 2'd0;
  localparam logic [1:0] LVL_Y = 2'd1;
  localparam logic [1:0] LVL_Z = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_SPLIT,
    OP_FADE_SQ,
    OP_FADE_CUBE,
    OP_FADE_INNER,
    OP_FADE_MUL,
    OP_FADE_STORE,
    OP_RD_X,
    OP_RD_Y,
    OP_RD_Z,
    OP_GRAD,
    OP_LERP_MUL,
    OP_LERP_ADD,
    OP_ACC_MUL,
    OP_ACC,
    OP_AMP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [1:0]       axis;
    logic [2:0]       corner;
    logic [1:0]       level;
    logic [OCT_W-1:0] octave;
  } cmd_t;

endpackage

/* src/perlin_octave_noise.sv */
// channel   direction  handshake                        payload
// command   in         start high while busy low        action_i, x/y/z_coord_i, table_*_i
// result    out        result_valid_o for one cycle     noise_value_o
// config    in/out     apb write: psel penable pwrite   paddr, pwdata, prdata
//
// a table load keeps busy high for 1 cycle
// a sample keeps busy high until all n octaves, in 3d or 2d mode, and the
// 40-step bit-serial divider are done; one shared 24x24 multiplier and the
// single table read port serve all octaves
// result_valid_o pulses in the cycle busy falls; the receiver cannot stall
// reset clears control and configuration, the permutation table is not cleared
module perlin_octave_noise (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic signed [31:0]                  x_coord_i,
  input  logic signed [31:0]                  y_coord_i,
  input  logic signed [31:0]                  z_coord_i,
  input  logic [pon_pkg::IDX_W-1:0]           table_index_i,
  input  logic [pon_pkg::IDX_W-1:0]           table_value_i,
  output logic                                result_valid_o,
  output logic signed [pon_pkg::OUT_W-1:0]    noise_value_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import pon_pkg::*;

  localparam logic [1:0] CFG_THREE_D = 2'd0;
  localparam logic [1:0] CFG_OCTAVES = 2'd1;
  localparam logic [1:0] CFG_PERSIST = 2'd2;
  localparam logic [1:0] CFG_UNIT    = 2'd3;
  localparam logic [PERS_W-1:0] PERS_MAX = PERS_W'(ONE_FX);

  logic                 three_d_q;
  logic [OCT_CNT_W-1:0] octaves_q;
  logic [PERS_W-1:0]    pers_q;
  logic                 unit_q;
  logic                 cfg_wr;
  logic [PERS_W-1:0]    pers_in;
  logic                 take;
  cmd_t                 cmd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pers_in = pwdata[PERS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_d_q <= 1'b1;
      octaves_q <= OCT_CNT_W'(1);
      pers_q    <= PERS_W'(ONE_FX / 2);
      unit_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        CFG_THREE_D: three_d_q <= pwdata[0];
        CFG_OCTAVES: octaves_q <= pwdata[OCT_CNT_W-1:0];
        CFG_PERSIST: pers_q    <= (pers_in > PERS_MAX) ? PERS_MAX : pers_in;
        CFG_UNIT:    unit_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_THREE_D: prdata = {31'd0, three_d_q};
      CFG_OCTAVES: prdata = {{(32 - OCT_CNT_W){1'b0}}, octaves_q};
      CFG_PERSIST: prdata = {{(32 - PERS_W){1'b0}}, pers_q};
      CFG_UNIT:    prdata = {31'd0, unit_q};
      default:     prdata = '0;
    endcase
  end

  assign take = start & ~busy;

  pon_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (take),
    .action_i  (action_i),
    .three_d_i (three_d_q),
    .octaves_i (octaves_q),
    .busy_o    (busy),
    .cmd_o     (cmd)
  );

  pon_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .three_d_i     (three_d_q),
    .unit_i        (unit_q),
    .pers_i        (pers_q),
    .cmd_i         (cmd),
    .valid_o       (result_valid_o),
    .noise_o       (noise_value_o)
  );

endmodule

/* src/pon_ctrl.sv */
module pon_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         action_i,
  input  logic                         three_d_i,
  input  logic [pon_pkg::OCT_CNT_W-1:0] octaves_i,
  output logic                         busy_o,
  output pon_pkg::cmd_t                cmd_o
);
  import pon_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_INIT, S_SPLIT,
    S_F1, S_F2, S_F3, S_F4, S_F5,
    S_RX, S_RY, S_RZ, S_GRAD,
    S_L0M, S_L0A, S_L1M, S_L1A, S_L2M, S_L2A,
    S_ACCM, S_ACC, S_AMP,
    S_DINIT, S_DIV, S_FIN
  } state_e;

  state_e             state_q;
  logic               busy_q;
  logic [1:0]         axis_q;
  logic [2:0]         corner_q;
  logic [OCT_W-1:0]   oct_q;
  logic [STEP_W-1:0]  step_q;
  logic [OCT_CNT_W-1:0] n_eff;
  logic [OCT_CNT_W-1:0] n_last;

  always_comb begin
    priority if (octaves_i == '0) begin
      n_eff = OCT_CNT_W'(1);
    end else if (octaves_i > OCT_CNT_W'(MAX_OCTAVES)) begin
      n_eff = OCT_CNT_W'(MAX_OCTAVES);
    end else begin
      n_eff = octaves_i;
    end
    n_last = n_eff - OCT_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      busy_q   <= 1'b0;
      axis_q   <= '0;
      corner_q <= '0;
      oct_q    <= '0;
      step_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            busy_q  <= 1'b1;
            state_q <= action_i ? S_LOAD : S_INIT;
          end
        end
        S_LOAD: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        S_INIT: begin
          oct_q   <= '0;
          state_q <= S_SPLIT;
        end
        S_SPLIT: begin
          axis_q  <= AXIS_X;
          state_q <= S_F1;
        end
        S_F1: state_q <= S_F2;
        S_F2: state_q <= S_F3;
        S_F3: state_q <= S_F4;
        S_F4: state_q <= S_F5;
        S_F5: begin
          if (axis_q == AXIS_Z) begin
            corner_q <= '0;
            state_q  <= S_RX;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_F1;
          end
        end
        S_RX: state_q <= S_RY;
        S_RY: state_q <= three_d_i ? S_RZ : S_GRAD;
        S_RZ: state_q <= S_GRAD;
        S_GRAD: begin
          if (!corner_q[0]) begin
            corner_q <= corner_q + 3'd1;
            state_q  <= S_RX;
          end else begin
            state_q <= S_L0M;
          end
        end
        S_L0M: state_q <= S_L0A;
        S_L0A: begin
          if (!corner_q[1]) begin
            corner_q <= corner_q + 3'd1;
            state_q  <= S_RX;
          end else begin
            state_q <= S_L1M;
          end
        end
        S_L1M: state_q <= S_L1A;
        S_L1A: begin
          priority if (!three_d_i) begin
            state_q <= S_ACCM;
          end else if (!corner_q[2]) begin
            corner_q <= corner_q + 3'd1;
            state_q  <= S_RX;
          end else begin
            state_q <= S_L2M;
          end
        end
        S_L2M: state_q <= S_L2A;
        S_L2A: state_q <= S_ACCM;
        S_ACCM: state_q <= S_ACC;
        S_ACC: state_q <= S_AMP;
        S_AMP: begin
          if (oct_q == n_last[OCT_W-1:0]) begin
            state_q <= S_DINIT;
          end else begin
            oct_q   <= oct_q + OCT_W'(1);
            state_q <= S_SPLIT;
          end
        end
        S_DINIT: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (step_q == STEP_W'(ACC_W - 1)) begin
            state_q <= S_FIN;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_FIN: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.axis   = axis_q;
    cmd_o.corner = corner_q;
    cmd_o.octave = oct_q;
    cmd_o.level  = LVL_X;
    unique case (state_q)
      S_LOAD:  cmd_o.op = OP_LOAD;
      S_INIT:  cmd_o.op = OP_INIT;
      S_SPLIT: cmd_o.op = OP_SPLIT;
      S_F1:    cmd_o.op = OP_FADE_SQ;
      S_F2:    cmd_o.op = OP_FADE_CUBE;
      S_F3:    cmd_o.op = OP_FADE_INNER;
      S_F4:    cmd_o.op = OP_FADE_MUL;
      S_F5:    cmd_o.op = OP_FADE_STORE;
      S_RX:    cmd_o.op = OP_RD_X;
      S_RY:    cmd_o.op = OP_RD_Y;
      S_RZ:    cmd_o.op = OP_RD_Z;
      S_GRAD:  cmd_o.op = OP_GRAD;
      S_L0M:   cmd_o.op = OP_LERP_MUL;
      S_L0A:   cmd_o.op = OP_LERP_ADD;
      S_L1M: begin
        cmd_o.op    = OP_LERP_MUL;
        cmd_o.level = LVL_Y;
      end
      S_L1A: begin
        cmd_o.op    = OP_LERP_ADD;
        cmd_o.level = LVL_Y;
      end
      S_L2M: begin
        cmd_o.op    = OP_LERP_MUL;
        cmd_o.level = LVL_Z;
      end
      S_L2A: begin
        cmd_o.op    = OP_LERP_ADD;
        cmd_o.level = LVL_Z;
      end
      S_ACCM:  cmd_o.op = OP_ACC_MUL;
      S_ACC:   cmd_o.op = OP_ACC;
      S_AMP:   cmd_o.op = OP_AMP;
      S_DINIT: cmd_o.op = OP_DIV_INIT;
      S_DIV:   cmd_o.op = OP_DIV_STEP;
      S_FIN:   cmd_o.op = OP_FINISH;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = busy_q;

endmodule

/* src/pon_dp.sv */
module pon_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic signed [31:0]               x_coord_i,
  input  logic signed [31:0]               y_coord_i,
  input  logic signed [31:0]               z_coord_i,
  input  logic [pon_pkg::IDX_W-1:0]        table_index_i,
  input  logic [pon_pkg::IDX_W-1:0]        table_value_i,
  input  logic                             three_d_i,
  input  logic                             unit_i,
  input  logic [pon_pkg::PERS_W-1:0]       pers_i,
  input  pon_pkg::cmd_t                    cmd_i,
  output logic                             valid_o,
  output logic signed [pon_pkg::OUT_W-1:0] noise_o
);
  import pon_pkg::*;

  localparam logic [3:0] H_U_LIMIT = 4'd8;
  localparam logic [3:0] H_V_LIMIT = 4'd4;
  localparam logic [3:0] H_SWAP_A  = 4'd12;
  localparam logic [3:0] H_SWAP_B  = 4'd14;
  localparam logic signed [MUL_W-1:0] FADE_B = MUL_W'(15 * ONE_FX);
  localparam logic signed [MUL_W-1:0] FADE_C = MUL_W'(10 * ONE_FX);
  localparam logic signed [GRAD_W-1:0] ONE_G = GRAD_W'(ONE_FX);
  localparam logic signed [ACC_W:0] ONE_R  = (ACC_W + 1)'(ONE_FX);
  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO = -((ACC_W + 1)'(1 << (OUT_W - 1)));

  function automatic logic signed [LERP_W-1:0] grad_f(
    input logic [3:0]               h,
    input logic signed [GRAD_W-1:0] gx,
    input logic signed [GRAD_W-1:0] gy,
    input logic signed [GRAD_W-1:0] gz
  );
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    logic signed [LERP_W-1:0] su;
    logic signed [LERP_W-1:0] sv;
    u  = (h < H_U_LIMIT) ? gx : gy;
    v  = (h < H_V_LIMIT) ? gy : ((h == H_SWAP_A || h == H_SWAP_B) ? gx : gz);
    su = h[0] ? -LERP_W'(u) : LERP_W'(u);
    sv = h[1] ? -LERP_W'(v) : LERP_W'(v);
    return su + sv;
  endfunction

  logic [IDX_W-1:0] perm_q [TABLE_SIZE];
  logic [IDX_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr;

  logic signed [31:0]      x_q, y_q, z_q;
  logic [IDX_W-1:0]        idx_q, val_q;
  logic [IDX_W-1:0]        cx_q, cy_q, cz_q;
  logic [FRAC_BITS-1:0]    fx_q, fy_q, fz_q;
  logic [FADE_W-1:0]       fu_q, fv_q, fw_q, t3_q;
  logic signed [LERP_W-1:0] ge_q, go_q, la_q, lb_q, lo_q, hi_q, s_q;
  logic signed [PROD_W-1:0] p_q;
  logic [PERS_W-1:0]       amp_q;
  logic signed [ACC_W-1:0] total_q;
  logic [WSUM_W-1:0]       wsum_q;
  logic [ACC_W-1:0]        mag_q, quot_q;
  logic [WSUM_W-1:0]       rem_q;
  logic                    neg_q;
  logic                    valid_q;
  logic signed [OUT_W-1:0] noise_q;

  logic [31:0]              shx, shy, shz;
  logic [FRAC_BITS-1:0]     t_fade;
  logic signed [MUL_W-1:0]  tt;
  logic signed [31:0]       p_sh;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [LERP_W-1:0] la_a, la_b;
  logic [FADE_W-1:0]        la_t;
  logic signed [LERP_W-1:0] lr;
  logic signed [GRAD_W-1:0] gx, gy, gz;
  logic signed [GRAD_W-1:0] fxs, fys, fzs;
  logic signed [LERP_W-1:0] gval;
  logic [WSUM_W:0]          rem_sh;
  logic signed [ACC_W:0]    r_s, r_u, r_sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      perm_q[idx_q] <= val_q;
    end
    rd_q <= perm_q[rd_addr];
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_RD_X: rd_addr = cx_q + IDX_W'(cmd_i.corner[0]);
      OP_RD_Y: rd_addr = rd_q + (three_d_i ? cy_q : cz_q) + IDX_W'(cmd_i.corner[1]);
      OP_RD_Z: rd_addr = rd_q + cz_q + IDX_W'(cmd_i.corner[2]);
      default: rd_addr = cx_q;
    endcase
  end

  assign shx  = x_q << cmd_i.octave;
  assign shy  = y_q << cmd_i.octave;
  assign shz  = z_q << cmd_i.octave;
  assign p_sh = $signed(p_q[PROD_W-1:FRAC_BITS]);

  always_comb begin
    unique case (cmd_i.axis)
      AXIS_Y:  t_fade = fy_q;
      AXIS_Z:  t_fade = fz_q;
      default: t_fade = fx_q;
    endcase
    tt = $signed({{(MUL_W - FRAC_BITS){1'b0}}, t_fade});
  end

  always_comb begin
    unique case (cmd_i.level)
      LVL_Y: begin
        la_a = la_q;
        la_b = lb_q;
        la_t = three_d_i ? fv_q : fw_q;
      end
      LVL_Z: begin
        la_a = lo_q;
        la_b = hi_q;
        la_t = fw_q;
      end
      default: begin
        la_a = ge_q;
        la_b = go_q;
        la_t = fu_q;
      end
    endcase
    lr = la_a + LERP_W'(p_sh);
  end

  always_comb begin
    fxs = $signed({2'b00, fx_q});
    fys = $signed({2'b00, fy_q});
    fzs = $signed({2'b00, fz_q});
    gx  = cmd_i.corner[0] ? fxs - ONE_G : fxs;
    if (three_d_i) begin
      gy = cmd_i.corner[1] ? fys - ONE_G : fys;
      gz = cmd_i.corner[2] ? fzs - ONE_G : fzs;
    end else begin
      gy = '0;
      gz = cmd_i.corner[1] ? fzs - ONE_G : fzs;
    end
    gval = grad_f(rd_q[3:0], gx, gy, gz);
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_FADE_SQ: begin
        ma = tt;
        mb = tt;
      end
      OP_FADE_CUBE: begin
        ma = MUL_W'(p_sh);
        mb = tt;
      end
      OP_FADE_INNER: begin
        ma = tt;
        mb = (tt <<< 2) + (tt <<< 1) - FADE_B;
      end
      OP_FADE_MUL: begin
        ma = $signed({{(MUL_W - FADE_W){1'b0}}, t3_q});
        mb = MUL_W'(p_sh) + FADE_C;
      end
      OP_LERP_MUL: begin
        ma = $signed({{(MUL_W - FADE_W){1'b0}}, la_t});
        mb = MUL_W'(la_b) - MUL_W'(la_a);
      end
      OP_ACC_MUL: begin
        ma = MUL_W'(s_q);
        mb = $signed({{(MUL_W - PERS_W){1'b0}}, amp_q});
      end
      OP_ACC: begin
        ma = $signed({{(MUL_W - PERS_W){1'b0}}, amp_q});
        mb = $signed({{(MUL_W - PERS_W){1'b0}}, pers_i});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    rem_sh = {rem_q, mag_q[ACC_W-1]};
    r_s    = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
    r_u    = unit_i ? ((r_s + ONE_R) >>> 1) : r_s;
    priority if (r_u > SAT_HI) begin
      r_sat = SAT_HI;
    end else if (r_u < SAT_LO) begin
      r_sat = SAT_LO;
    end else begin
      r_sat = r_u;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= ma * mb;
    if (take_i) begin
      x_q   <= x_coord_i;
      y_q   <= y_coord_i;
      z_q   <= z_coord_i;
      idx_q <= table_index_i;
      val_q <= table_value_i;
    end
    unique case (cmd_i.op)
      OP_INIT: begin
        total_q <= '0;
        wsum_q  <= '0;
        amp_q   <= PERS_W'(ONE_FX);
      end
      OP_SPLIT: begin
        cx_q <= shx[FRAC_BITS+IDX_W-1:FRAC_BITS];
        cy_q <= shy[FRAC_BITS+IDX_W-1:FRAC_BITS];
        cz_q <= shz[FRAC_BITS+IDX_W-1:FRAC_BITS];
        fx_q <= shx[FRAC_BITS-1:0];
        fy_q <= shy[FRAC_BITS-1:0];
        fz_q <= shz[FRAC_BITS-1:0];
      end
      OP_FADE_INNER: t3_q <= p_sh[FADE_W-1:0];
      OP_FADE_STORE: begin
        unique case (cmd_i.axis)
          AXIS_Y:  fv_q <= p_sh[FADE_W-1:0];
          AXIS_Z:  fw_q <= p_sh[FADE_W-1:0];
          default: fu_q <= p_sh[FADE_W-1:0];
        endcase
      end
      OP_GRAD: begin
        if (cmd_i.corner[0]) begin
          go_q <= gval;
        end else begin
          ge_q <= gval;
        end
      end
      OP_LERP_ADD: begin
        unique case (cmd_i.level)
          LVL_Y: begin
            priority if (!three_d_i) begin
              s_q <= lr;
            end else if (cmd_i.corner[2]) begin
              hi_q <= lr;
            end else begin
              lo_q <= lr;
            end
          end
          LVL_Z: s_q <= lr;
          default: begin
            if (cmd_i.corner[1]) begin
              lb_q <= lr;
            end else begin
              la_q <= lr;
            end
          end
        endcase
      end
      OP_ACC: begin
        total_q <= total_q + ACC_W'(p_q);
        wsum_q  <= wsum_q + WSUM_W'(amp_q);
      end
      OP_AMP: amp_q <= p_q[FRAC_BITS+PERS_W-1:FRAC_BITS];
      OP_DIV_INIT: begin
        neg_q  <= total_q[ACC_W-1];
        mag_q  <= total_q[ACC_W-1] ? ACC_W'(-total_q) : ACC_W'(total_q);
        rem_q  <= '0;
        quot_q <= '0;
      end
      OP_DIV_STEP: begin
        mag_q <= mag_q << 1;
        if (rem_sh >= {1'b0, wsum_q}) begin
          rem_q  <= WSUM_W'(rem_sh - {1'b0, wsum_q});
          quot_q <= {quot_q[ACC_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[WSUM_W-1:0];
          quot_q <= {quot_q[ACC_W-2:0], 1'b0};
        end
      end
      OP_FINISH: noise_q <= OUT_W'(r_sat);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.op == OP_FINISH);
    end
  end

  assign valid_o = valid_q;
  assign noise_o = noise_q;

endmodule

/* src/pon_checker.sv */
module pon_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic action_i,
  input logic result_valid_o,
  input logic pready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result without a finishing sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i) |=> (busy ##1 (!busy && !result_valid_o)))
    else $error("table load transfer misbehaved");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !action_i) |=> (busy ##1 busy))
    else $error("sample ended too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port not ready");

endmodule

bind perlin_octave_noise pon_checker u_pon_checker (.*);
